FILE: rtl/sfr_pkg.sv
package sfr_pkg;

	localparam int unsigned CharW = 8;
	localparam int unsigned CfgAddrW = 5;
	localparam int unsigned CfgDataW = 64;

	typedef enum logic [1:0] {
		REG_PATTERN_BYTES      = 2'd0,
		REG_PATTERN_LENGTH     = 2'd1,
		REG_REPLACEMENT_BYTES  = 2'd2,
		REG_REPLACEMENT_LENGTH = 2'd3
	} reg_idx_t;

	typedef struct packed {
		logic [CharW-1:0] in_char;
		logic             in_last;
	} in_item_t;

	typedef struct packed {
		logic [CharW-1:0] out_char;
		logic             out_valid;
		logic             out_last;
	} out_item_t;

	typedef struct packed {
		logic [63:0] pattern_bytes;
		logic [3:0]  pattern_length;
		logic [63:0] replacement_bytes;
		logic [3:0]  replacement_length;
	} cfg_regs_t;

	typedef struct packed {
		logic push;
		logic pop;
	} cell_ctl_t;

endpackage

FILE: rtl/sfr_cell.sv
module sfr_cell
	import sfr_pkg::*;
#(
	parameter int unsigned IDX = 0,
	parameter int unsigned FW  = 4
) (
	input  logic             clk,
	input  cell_ctl_t        ctl,
	input  logic [FW-1:0]    fill,
	input  logic [FW-1:0]    plen,
	input  logic [CharW-1:0] in_char,
	input  logic [CharW-1:0] next_char,
	input  logic [CharW-1:0] pat_char,
	input  logic             match_in,
	output logic [CharW-1:0] char_out,
	output logic             match_out
);

	logic [CharW-1:0] char_q;
	logic             active;

	// A pop moves every character one place towards the head; a push lands at the fill point.
	always_ff @(posedge clk) begin
		if (ctl.pop) begin
			char_q <= next_char;
		end else if (ctl.push && fill == FW'(IDX)) begin
			char_q <= in_char;
		end
	end

	assign active    = FW'(IDX) < plen;
	assign char_out  = char_q;
	assign match_out = match_in & (~active | (char_q == pat_char));

endmodule

FILE: rtl/sfr_cfg.sv
module sfr_cfg
	import sfr_pkg::*;
(
	input  logic                clk,
	input  logic                arst_n,
	input  logic                psel,
	input  logic                penable,
	input  logic                pwrite,
	input  logic [CfgAddrW-1:0] paddr,
	input  logic [CfgDataW-1:0] pwdata,
	output logic [CfgDataW-1:0] prdata,
	output logic                pready,
	output cfg_regs_t           regs,
	output logic                plen_wr
);

	cfg_regs_t regs_q;
	reg_idx_t  idx;
	logic      wr;

	assign pready = 1'b1;
	assign idx    = reg_idx_t'(paddr[CfgAddrW-1:3]);
	assign wr     = psel & penable & pwrite;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			regs_q.pattern_bytes      <= '0;
			regs_q.pattern_length     <= 4'd1;
			regs_q.replacement_bytes  <= '0;
			regs_q.replacement_length <= '0;
		end else if (wr) begin
			unique case (idx)
				REG_PATTERN_BYTES:      regs_q.pattern_bytes      <= pwdata;
				REG_PATTERN_LENGTH:     regs_q.pattern_length     <= pwdata[3:0];
				REG_REPLACEMENT_BYTES:  regs_q.replacement_bytes  <= pwdata;
				REG_REPLACEMENT_LENGTH: regs_q.replacement_length <= pwdata[3:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		unique case (idx)
			REG_PATTERN_BYTES:      prdata = regs_q.pattern_bytes;
			REG_PATTERN_LENGTH:     prdata = {60'd0, regs_q.pattern_length};
			REG_REPLACEMENT_BYTES:  prdata = regs_q.replacement_bytes;
			REG_REPLACEMENT_LENGTH: prdata = {60'd0, regs_q.replacement_length};
			default:                prdata = '0;
		endcase
	end

	assign regs    = regs_q;
	assign plen_wr = wr && idx == REG_PATTERN_LENGTH;

endmodule

FILE: rtl/stream_find_and_replace.sv
// Streaming find-and-replace: every non-overlapping occurrence of the pattern (pattern_bytes,
// pattern_length 1..8, first character in the lowest byte) is replaced by replacement_length
// characters of replacement_bytes; other characters pass through in order. Registers sit at
// APB byte addresses 0x00 pattern_bytes, 0x08 pattern_length, 0x10 replacement_bytes and
// 0x18 replacement_length; writing pattern_length empties the window, so configure between
// strings. One request is handled at a time: it is taken in ST_IDLE, compared against the
// pattern in ST_EVAL, and each result it causes then passes through the single output
// register (at most 8 results, an end-of-string flush included); a stalled output holds the
// request up. On a string's last request that leaves nothing to emit, a bare result with
// out_valid clear and out_last set is given.
module stream_find_and_replace
	import sfr_pkg::*;
#(
	parameter int unsigned PATTERN_MAX = 8,
	parameter int unsigned REPLACE_MAX = 8
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                in_valid,
	output logic                in_stall,
	input  in_item_t            in_item,
	output logic                res_valid,
	input  logic                res_stall,
	output out_item_t           res_item,
	input  logic                psel,
	input  logic                penable,
	input  logic                pwrite,
	input  logic [CfgAddrW-1:0] paddr,
	input  logic [CfgDataW-1:0] pwdata,
	output logic [CfgDataW-1:0] prdata,
	output logic                pready
);

	localparam int unsigned FW = $clog2(PATTERN_MAX + 1);
	localparam int unsigned RW = (REPLACE_MAX > 1) ? $clog2(REPLACE_MAX) : 1;

	typedef enum logic [4:0] {
		ST_IDLE = 5'b00001,
		ST_EVAL = 5'b00010,
		ST_REPL = 5'b00100,
		ST_HEAD = 5'b01000,
		ST_MARK = 5'b10000
	} state_t;

	cfg_regs_t        regs;
	logic             plen_wr;
	state_t           state_q;
	logic [FW-1:0]    fill_q;
	logic             last_q;
	logic [RW-1:0]    rcnt_q;
	logic             res_valid_q;
	out_item_t        res_item_q;
	logic [3:0]       plen4;
	logic [3:0]       rlen4;
	logic [FW-1:0]    plen;
	logic             accept;
	logic             out_free;
	logic             full;
	logic             match;
	logic             repl_end;
	cell_ctl_t        ctl;
	logic [CharW-1:0] chars [PATTERN_MAX+1];
	logic             mchain [PATTERN_MAX+1];
	logic [CharW-1:0] repl_chars [REPLACE_MAX];

	sfr_cfg u_cfg (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready),
		.regs    (regs),
		.plen_wr (plen_wr)
	);

	always_comb begin
		priority if (regs.pattern_length == 4'd0) begin
			plen4 = 4'd1;
		end else if (regs.pattern_length > 4'(PATTERN_MAX)) begin
			plen4 = 4'(PATTERN_MAX);
		end else begin
			plen4 = regs.pattern_length;
		end
		rlen4 = (regs.replacement_length > 4'(REPLACE_MAX)) ? 4'(REPLACE_MAX)
			: regs.replacement_length;
	end

	assign plen = plen4[FW-1:0];

	for (genvar r = 0; r < REPLACE_MAX; r++) begin : g_repl
		assign repl_chars[r] = regs.replacement_bytes[8*r +: 8];
	end

	assign in_stall = state_q != ST_IDLE;
	assign accept   = in_valid && state_q == ST_IDLE;
	assign out_free = !res_valid_q || !res_stall;
	assign full     = fill_q == plen;
	assign repl_end = (4'(rcnt_q) + 4'd1) == rlen4;

	assign ctl.push = accept;
	assign ctl.pop  = state_q == ST_HEAD && out_free;

	assign chars[PATTERN_MAX] = '0;
	assign mchain[0]          = 1'b1;
	assign match              = mchain[PATTERN_MAX];

	for (genvar k = 0; k < PATTERN_MAX; k++) begin : g_cell
		sfr_cell #(
			.IDX (k),
			.FW  (FW)
		) u_cell (
			.clk       (clk),
			.ctl       (ctl),
			.fill      (fill_q),
			.plen      (plen),
			.in_char   (in_item.in_char),
			.next_char (chars[k+1]),
			.pat_char  (regs.pattern_bytes[8*k +: 8]),
			.match_in  (mchain[k]),
			.char_out  (chars[k]),
			.match_out (mchain[k+1])
		);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			fill_q      <= '0;
			last_q      <= 1'b0;
			rcnt_q      <= '0;
			res_valid_q <= 1'b0;
		end else begin
			if (out_free) begin
				res_valid_q <= 1'b0;
			end
			if (plen_wr) begin
				fill_q <= '0;
			end
			unique case (state_q)
				ST_IDLE: begin
					if (accept) begin
						fill_q  <= fill_q + 1'b1;
						last_q  <= in_item.in_last;
						state_q <= ST_EVAL;
					end
				end
				ST_EVAL: begin
					rcnt_q <= '0;
					if (full && match) begin
						fill_q <= '0;
						priority if (rlen4 != 4'd0) begin
							state_q <= ST_REPL;
						end else if (last_q) begin
							state_q <= ST_MARK;
						end else begin
							state_q <= ST_IDLE;
						end
					end else if (full || last_q) begin
						// A mismatch releases the oldest character; the string's end flushes all.
						state_q <= ST_HEAD;
					end else begin
						state_q <= ST_IDLE;
					end
				end
				ST_REPL: begin
					if (out_free) begin
						res_valid_q <= 1'b1;
						rcnt_q      <= rcnt_q + 1'b1;
						if (repl_end) begin
							state_q <= ST_IDLE;
						end
					end
				end
				ST_HEAD: begin
					if (out_free) begin
						res_valid_q <= 1'b1;
						fill_q      <= fill_q - 1'b1;
						if (!last_q || fill_q == FW'(1)) begin
							state_q <= ST_IDLE;
						end
					end
				end
				ST_MARK: begin
					if (out_free) begin
						res_valid_q <= 1'b1;
						state_q     <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (out_free) begin
			unique case (state_q)
				ST_REPL: begin
					res_item_q.out_char  <= repl_chars[rcnt_q];
					res_item_q.out_valid <= 1'b1;
					res_item_q.out_last  <= last_q && repl_end;
				end
				ST_HEAD: begin
					res_item_q.out_char  <= chars[0];
					res_item_q.out_valid <= 1'b1;
					res_item_q.out_last  <= last_q && fill_q == FW'(1);
				end
				ST_MARK: begin
					res_item_q.out_char  <= '0;
					res_item_q.out_valid <= 1'b0;
					res_item_q.out_last  <= 1'b1;
				end
				default: ;
			endcase
		end
	end

	assign res_valid = res_valid_q;
	assign res_item  = res_item_q;

endmodule
